// File: hdl/zero_marked_byte_fifo_with_terminator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the zero-marked byte FIFO
// Shared property wrappers, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_MARKED_BYTE_FIFO_WITH_TERMINATOR_DEFINES_SVH
`define ZERO_MARKED_BYTE_FIFO_WITH_TERMINATOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define ZMBFT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define ZMBFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/zmbft_pkg.sv
// ----------------------------------------------------------------------------
// zmbft_pkg
// Constants, types and index helpers for the zero-marked byte FIFO.
// ----------------------------------------------------------------------------
package zmbft_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CNT_W   = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [BYTE_W-1:0] TERM_LAST_RST  = 8'h0A;
    localparam logic [BYTE_W-1:0] TERM_PREV_RST  = 8'h0D;
    localparam logic [CNT_W-1:0]  TERM_COUNT_RST = 2'd2;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_TERM_LAST  = 2'd0;
    localparam logic [1:0] REG_TERM_PREV  = 2'd1;
    localparam logic [1:0] REG_TERM_COUNT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef logic [IDX_W-1:0] idx_t;

    function automatic idx_t idx_inc(input idx_t idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic idx_t idx_dec(input idx_t idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
    endfunction

endpackage

// File: hdl/zero_marked_byte_fifo_with_terminator.sv
// ----------------------------------------------------------------------------
// zero_marked_byte_fifo_with_terminator
// Circular byte queue where a zero byte marks a free slot, with an APB
// programmable terminator check reported after every transaction.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  s_       | s_valid / s_ready  | s_kind, s_data_in
//  m_       | m_valid / m_ready  | m_read_data, m_status, m_empty_res,
//           |                    | m_message_complete
//  apb      | psel/penable/...   | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while m_ready stays high; m_valid rises once
// an accepted input has passed the input register and then the result register.
// The slot memory is a single-write, single-read array; a one-bit occupancy
// flop per slot marks non-zero bytes, so clear and full-wipe leave the array alone.
// Reset is synchronous on aresetn; no clearing pass is needed after it.
// A stalled m_ready holds the result register and backs up into s_ready.
// ----------------------------------------------------------------------------
module zero_marked_byte_fifo_with_terminator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [zmbft_pkg::KIND_W-1:0]     s_kind,
    input  logic [zmbft_pkg::BYTE_W-1:0]     s_data_in,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [zmbft_pkg::BYTE_W-1:0]     m_read_data,
    output logic                             m_status,
    output logic                             m_empty_res,
    output logic                             m_message_complete,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [zmbft_pkg::PADDR_W-1:0]    paddr,
    input  logic [zmbft_pkg::PDATA_W-1:0]    pwdata,
    output logic [zmbft_pkg::PDATA_W-1:0]    prdata,
    output logic                             pready
);
    import zmbft_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0] term_last_reg;
    logic [BYTE_W-1:0] term_prev_reg;
    logic [CNT_W-1:0]  term_count_reg;
    logic              cfg_wr;

    // input register
    logic              in_vld_reg;
    kind_t             in_kind_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              accept;
    logic              adv;

    // queue state
    logic [DEPTH-1:0]  occ_reg, occ_next;
    idx_t              widx_reg, widx_next;
    idx_t              ridx_reg, ridx_next;
    logic              empty_reg, empty_next;
    // shadow copies of the slots one and two behind the write index
    logic [BYTE_W-1:0] last1_reg, last1_next;
    logic [BYTE_W-1:0] last2_reg, last2_next;
    idx_t              prev1;
    idx_t              prev2;

    // slot memory
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] mem_rd_reg;
    logic              byp_reg;
    logic [BYTE_W-1:0] byp_data_reg;
    logic              mem_we;
    idx_t              mem_wa;
    logic [BYTE_W-1:0] mem_wd;
    logic [BYTE_W-1:0] slot_rd;

    // per-transaction results
    logic [BYTE_W-1:0] rd_byte;
    logic              full;
    logic              wipe;
    logic              term_hit;

    // result register
    logic              out_vld_reg;
    logic [BYTE_W-1:0] out_rd_reg;
    logic              out_st_reg;
    logic              out_empty_reg;
    logic              out_mc_reg;

    // ------------------------------------------------------------------
    // APB: zero-wait writes, combinational read-back
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_last_reg  <= TERM_LAST_RST;
            term_prev_reg  <= TERM_PREV_RST;
            term_count_reg <= TERM_COUNT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TERM_LAST:  term_last_reg  <= pwdata[BYTE_W-1:0];
                REG_TERM_PREV:  term_prev_reg  <= pwdata[BYTE_W-1:0];
                REG_TERM_COUNT: term_count_reg <= pwdata[CNT_W-1:0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TERM_LAST:  prdata = PDATA_W'(term_last_reg);
            REG_TERM_PREV:  prdata = PDATA_W'(term_prev_reg);
            REG_TERM_COUNT: prdata = PDATA_W'(term_count_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: advance the input register whenever the result register
    // is free or being drained this cycle.
    // ------------------------------------------------------------------
    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (accept) begin
            in_vld_reg <= 1'b1;
        end else if (adv) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_kind_reg <= kind_t'(s_kind);
            in_data_reg <= s_data_in;
        end
    end

    // ------------------------------------------------------------------
    // Queue update for the transaction in the input register
    // ------------------------------------------------------------------
    assign prev1 = idx_dec(widx_reg);
    assign prev2 = idx_dec(prev1);

    // A free slot always reads as zero; the registered memory word is only
    // trusted when the occupancy bit says the slot holds a byte.
    assign slot_rd = occ_reg[ridx_reg] ? (byp_reg ? byp_data_reg : mem_rd_reg)
                                       : '0;

    always_comb begin
        occ_next   = occ_reg;
        widx_next  = widx_reg;
        ridx_next  = ridx_reg;
        empty_next = empty_reg;
        last1_next = last1_reg;
        last2_next = last2_reg;
        mem_we     = 1'b0;
        mem_wa     = widx_reg;
        mem_wd     = in_data_reg;
        rd_byte    = '0;
        full       = 1'b0;
        wipe       = 1'b0;
        if (adv) begin
            case (in_kind_reg)
                KIND_WRITE: begin
                    empty_next = 1'b0;
                    if (!occ_reg[widx_reg]) begin
                        // store the byte; a zero byte leaves the slot free
                        occ_next[widx_reg] = |in_data_reg;
                        mem_we             = 1'b1;
                        widx_next          = idx_inc(widx_reg);
                        last2_next         = last1_reg;
                        last1_next         = in_data_reg;
                    end else begin
                        full = 1'b1;
                        wipe = 1'b1;
                    end
                end
                KIND_READ: begin
                    rd_byte            = slot_rd;
                    occ_next[ridx_reg] = 1'b0;
                    if (slot_rd == '0) begin
                        empty_next = 1'b1;
                    end else begin
                        empty_next = 1'b0;
                        ridx_next  = idx_inc(ridx_reg);
                    end
                    // keep the terminator shadows in step with the zeroed slot
                    if (ridx_reg == prev1) begin
                        last1_next = '0;
                    end
                    if (ridx_reg == prev2) begin
                        last2_next = '0;
                    end
                end
                KIND_CLEAR: begin
                    wipe = 1'b1;
                end
                default: ;  // unused kind: leave state alone
            endcase
        end
        if (wipe) begin
            occ_next   = '0;
            widx_next  = '0;
            ridx_next  = '0;
            empty_next = 1'b1;
            last1_next = '0;
            last2_next = '0;
        end
    end

    assign term_hit = (last1_next == term_last_reg) &&
                      (!term_count_reg[1] || (last2_next == term_prev_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            widx_reg  <= '0;
            ridx_reg  <= '0;
            empty_reg <= 1'b1;
            last1_reg <= '0;
            last2_reg <= '0;
        end else begin
            occ_reg   <= occ_next;
            widx_reg  <= widx_next;
            ridx_reg  <= ridx_next;
            empty_reg <= empty_next;
            last1_reg <= last1_next;
            last2_reg <= last2_next;
        end
    end

    // ------------------------------------------------------------------
    // Slot memory: prefetch the word at the next read index so it is
    // ready for the following transaction; bypass a same-cycle write.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg   <= mem[ridx_next];
        byp_reg      <= mem_we && (mem_wa == ridx_next);
        byp_data_reg <= mem_wd;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_rd_reg    <= rd_byte;
            out_st_reg    <= full;
            out_empty_reg <= empty_next;
            out_mc_reg    <= term_hit;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_read_data        = out_rd_reg;
    assign m_status           = out_st_reg;
    assign m_empty_res        = out_empty_reg;
    assign m_message_complete = out_mc_reg;

endmodule

// File: hdl/zmbft_checker.sv
// ----------------------------------------------------------------------------
// zmbft_checker
// Port-level checks for the zero-marked byte FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "zero_marked_byte_fifo_with_terminator_defines.svh"

module zmbft_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [zmbft_pkg::BYTE_W-1:0]     m_read_data,
    input logic                             m_status,
    input logic                             m_empty_res,
    input logic                             m_message_complete
);

    // a full write wipes the store, so the result must show empty, no data
    `ZMBFT_ASSERT_NOW(a_full_wipes, m_valid && m_status, m_empty_res && (m_read_data == '0), "full without wipe")

    // a non-zero byte read means the queue was not empty
    `ZMBFT_ASSERT_NOW(a_data_not_empty, m_valid && (m_read_data != '0), !m_empty_res && !m_status, "data with empty")

    // with no input offered and a free result side, the input side must become ready
    `ZMBFT_ASSERT_NEXT(a_no_stall, !m_valid && !s_valid, s_ready, "ready stuck low")

    // a stalled result holds
    `ZMBFT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_read_data) && $stable(m_status) && $stable(m_empty_res) && $stable(m_message_complete), "result changed under stall")

endmodule

bind zero_marked_byte_fifo_with_terminator zmbft_checker u_zmbft_checker (.*);
